[hdl/tun_pkg.sv]
`default_nettype none
package tun_pkg;

  // register stages from the input ports to the lane inputs
  localparam int FRONT_STAGES = 7;
  // one lane per normal component
  localparam int LANES = 3;

endpackage
`default_nettype wire

[hdl/tun_front.sv]
`default_nettype none
module tun_front #(
  parameter int COORD_BITS = 24,
  localparam int M = 2 * COORD_BITS + 2,
  localparam int SW = 2 * M + 2
) (
  input  logic                                   clk_i,
  input  logic [tun_pkg::FRONT_STAGES-1:0]       en_i,
  input  logic signed [COORD_BITS-1:0]           first_x_i,
  input  logic signed [COORD_BITS-1:0]           first_y_i,
  input  logic signed [COORD_BITS-1:0]           first_z_i,
  input  logic signed [COORD_BITS-1:0]           second_x_i,
  input  logic signed [COORD_BITS-1:0]           second_y_i,
  input  logic signed [COORD_BITS-1:0]           second_z_i,
  input  logic signed [COORD_BITS-1:0]           third_x_i,
  input  logic signed [COORD_BITS-1:0]           third_y_i,
  input  logic signed [COORD_BITS-1:0]           third_z_i,
  output logic [tun_pkg::LANES-1:0][2*M-1:0]     sq_o,
  output logic [SW-1:0]                          sum_o,
  output logic [tun_pkg::LANES-1:0]              neg_o,
  output logic                                   degenerate_o
);
  import tun_pkg::*;

  localparam int D  = COORD_BITS + 1;
  localparam int CW = 2 * D + 1;
  localparam int K  = (M + 1) / 2;
  localparam int H  = M - K;

  logic signed [D-1:0]    ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [2*D-1:0]  pr_q [6];
  logic signed [CW-1:0]   cr_q [LANES];
  logic [M-1:0]           mag_q [LANES];
  logic [2*H-1:0]         hh_q [LANES];
  logic [H+K-1:0]         hl_q [LANES];
  logic [2*K-1:0]         ll_q [LANES];
  logic [2*M-1:0]         sq6_q [LANES];
  logic [2*M-1:0]         sq7_q [LANES];
  logic [SW-1:0]          sum_q;
  logic [LANES-1:0]       neg4_q, neg5_q, neg6_q, neg7_q;
  logic                   dg4_q, dg5_q, dg6_q, dg7_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ax_q <= D'(second_x_i) - D'(first_x_i);
      ay_q <= D'(second_y_i) - D'(first_y_i);
      az_q <= D'(second_z_i) - D'(first_z_i);
      bx_q <= D'(third_x_i) - D'(first_x_i);
      by_q <= D'(third_y_i) - D'(first_y_i);
      bz_q <= D'(third_z_i) - D'(first_z_i);
    end
    if (en_i[1]) begin
      pr_q[0] <= (2*D)'(ay_q) * (2*D)'(bz_q);
      pr_q[1] <= (2*D)'(az_q) * (2*D)'(by_q);
      pr_q[2] <= (2*D)'(az_q) * (2*D)'(bx_q);
      pr_q[3] <= (2*D)'(ax_q) * (2*D)'(bz_q);
      pr_q[4] <= (2*D)'(ax_q) * (2*D)'(by_q);
      pr_q[5] <= (2*D)'(ay_q) * (2*D)'(bx_q);
    end
    if (en_i[2]) begin
      for (int k = 0; k < LANES; k++) begin
        cr_q[k] <= CW'(pr_q[2*k]) - CW'(pr_q[2*k+1]);
      end
    end
    if (en_i[3]) begin
      for (int k = 0; k < LANES; k++) begin
        mag_q[k]  <= cr_q[k][CW-1] ? M'(-cr_q[k]) : M'(cr_q[k]);
        neg4_q[k] <= cr_q[k][CW-1];
      end
      dg4_q <= (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
    end
    // squares split into half-width partial products
    if (en_i[4]) begin
      for (int k = 0; k < LANES; k++) begin
        hh_q[k] <= (2*H)'(mag_q[k][M-1:K]) * (2*H)'(mag_q[k][M-1:K]);
        hl_q[k] <= (H+K)'(mag_q[k][M-1:K]) * (H+K)'(mag_q[k][K-1:0]);
        ll_q[k] <= (2*K)'(mag_q[k][K-1:0]) * (2*K)'(mag_q[k][K-1:0]);
      end
      neg5_q <= neg4_q;
      dg5_q  <= dg4_q;
    end
    if (en_i[5]) begin
      for (int k = 0; k < LANES; k++) begin
        sq6_q[k] <= ((2*M)'(hh_q[k]) << (2*K)) + ((2*M)'(hl_q[k]) << (K+1))
                    + (2*M)'(ll_q[k]);
      end
      neg6_q <= neg5_q;
      dg6_q  <= dg5_q;
    end
    if (en_i[6]) begin
      sum_q <= SW'(sq6_q[0]) + SW'(sq6_q[1]) + SW'(sq6_q[2]);
      for (int k = 0; k < LANES; k++) begin
        sq7_q[k] <= sq6_q[k];
      end
      neg7_q <= neg6_q;
      dg7_q  <= dg6_q;
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      sq_o[k] = sq7_q[k];
    end
  end

  assign sum_o        = sum_q;
  assign neg_o        = neg7_q;
  assign degenerate_o = dg7_q;

endmodule
`default_nettype wire

[hdl/tun_lane.sv]
`default_nettype none
module tun_lane #(
  parameter int COORD_BITS = 24,
  parameter int NORMAL_BITS = 16,
  localparam int M = 2 * COORD_BITS + 2,
  localparam int SW = 2 * M + 2,
  localparam int STAGES = NORMAL_BITS + 1
) (
  input  logic                    clk_i,
  input  logic [STAGES-1:0]       en_i,
  input  logic [2*M-1:0]          sq_i,
  input  logic [SW-1:0]           sum_i,
  input  logic                    neg_i,
  output logic [NORMAL_BITS-1:0]  q_o,
  output logic                    neg_o
);
  import tun_pkg::*;

  localparam int F  = NORMAL_BITS - 1;
  localparam int RW = 2 * M + 2 * F + 7;
  localparam int PW = SW + F + 3;

  // r = c^2 * 2^(2F+2) - d^2 * s, p = d * s, with d = 2q - 1
  logic signed [RW-1:0]     r_q [STAGES];
  logic signed [PW-1:0]     p_q [STAGES];
  logic [SW-1:0]            s_q [STAGES];
  logic [NORMAL_BITS-1:0]   q_q [STAGES];
  logic [STAGES-1:0]        n_q;
  logic signed [RW-1:0]     r_try [STAGES];
  logic [STAGES-1:0]        take;

  always_comb begin
    int b;
    r_try[0] = '0;
    take[0]  = 1'b0;
    for (int j = 1; j < STAGES; j++) begin
      b = F + 1 - j;
      r_try[j] = r_q[j-1] - (RW'(p_q[j-1]) <<< (b + 2)) - (RW'(s_q[j-1]) << (2 * b + 2));
      // once q reaches 1.0 no lower bit may be added
      take[j] = !r_try[j][RW-1] && !((b < F) && q_q[j-1][F]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0] <= (RW'(sq_i) << (2 * F + 2)) - RW'(sum_i);
      p_q[0] <= -PW'(sum_i);
      s_q[0] <= sum_i;
      q_q[0] <= '0;
      n_q[0] <= neg_i;
    end
    for (int j = 1; j < STAGES; j++) begin
      if (en_i[j]) begin
        r_q[j] <= take[j] ? r_try[j] : r_q[j-1];
        p_q[j] <= take[j] ? p_q[j-1] + (PW'(s_q[j-1]) << (F + 2 - j)) : p_q[j-1];
        s_q[j] <= s_q[j-1];
        q_q[j] <= q_q[j-1] | (take[j] ? (NORMAL_BITS'(1) << (F + 1 - j)) : '0);
        n_q[j] <= n_q[j-1];
      end
    end
  end

  assign q_o   = q_q[STAGES-1];
  assign neg_o = n_q[STAGES-1];

endmodule
`default_nettype wire

[hdl/triangle_unit_normal.sv]
// Pipeline from input transfer to result:
// 7 front stages (edges, products, cross, magnitude, squares, sum), NORMAL_BITS + 1
// stages of the per-component root-division recurrence, one output register.
// Throughput: one triangle per cycle unless the pipeline is full and stalled; stages
// advance independently, so bubbles close up while the output register holds a result.
// Reset: rst_ni async active low clears all valid bits; payload is not reset.
`default_nettype none
module triangle_unit_normal #(
  parameter int COORD_BITS = 24,
  parameter int NORMAL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COORD_BITS-1:0]   first_x_i,
  input  logic signed [COORD_BITS-1:0]   first_y_i,
  input  logic signed [COORD_BITS-1:0]   first_z_i,
  input  logic signed [COORD_BITS-1:0]   second_x_i,
  input  logic signed [COORD_BITS-1:0]   second_y_i,
  input  logic signed [COORD_BITS-1:0]   second_z_i,
  input  logic signed [COORD_BITS-1:0]   third_x_i,
  input  logic signed [COORD_BITS-1:0]   third_y_i,
  input  logic signed [COORD_BITS-1:0]   third_z_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [NORMAL_BITS-1:0]  normal_x_o,
  output logic signed [NORMAL_BITS-1:0]  normal_y_o,
  output logic signed [NORMAL_BITS-1:0]  normal_z_o,
  output logic                           degenerate_o
);
  import tun_pkg::*;

  localparam int M    = 2 * COORD_BITS + 2;
  localparam int SW   = 2 * M + 2;
  localparam int F    = NORMAL_BITS - 1;
  localparam int LS   = NORMAL_BITS + 1;
  localparam int NSTG = FRONT_STAGES + LS;

  logic [NSTG-1:0]                  v_q;
  logic [NSTG-1:0]                  en;
  logic                             en_out;
  logic                             out_valid_q;
  logic [LANES-1:0][2*M-1:0]        sq;
  logic [SW-1:0]                    sum;
  logic [LANES-1:0]                 neg;
  logic                             dg_front;
  logic [LS-1:0]                    dg_q;
  logic [NORMAL_BITS-1:0]           lane_q [LANES];
  logic [LANES-1:0]                 lane_neg;
  logic signed [NORMAL_BITS-1:0]    nrm_d [LANES];
  logic signed [NORMAL_BITS-1:0]    nrm_q [LANES];
  logic                             dg_out_q;

  // a stage moves when the output frees up or a bubble sits at or after it
  assign en_out = !out_valid_q || out_ready_i;
  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      en[i] = en_out || (((~v_q) >> i) != '0);
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
      if (en_out) out_valid_q <= v_q[NSTG-1];
    end
  end

  tun_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i,
    .en_i         (en[FRONT_STAGES-1:0]),
    .first_x_i, .first_y_i, .first_z_i,
    .second_x_i, .second_y_i, .second_z_i,
    .third_x_i, .third_y_i, .third_z_i,
    .sq_o         (sq),
    .sum_o        (sum),
    .neg_o        (neg),
    .degenerate_o (dg_front)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    tun_lane #(.COORD_BITS(COORD_BITS), .NORMAL_BITS(NORMAL_BITS)) u_lane (
      .clk_i,
      .en_i  (en[NSTG-1:FRONT_STAGES]),
      .sq_i  (sq[k]),
      .sum_i (sum),
      .neg_i (neg[k]),
      .q_o   (lane_q[k]),
      .neg_o (lane_neg[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[FRONT_STAGES]) dg_q[0] <= dg_front;
    for (int j = 1; j < LS; j++) begin
      if (en[FRONT_STAGES+j]) dg_q[j] <= dg_q[j-1];
    end
  end

  // merge: sign, saturate +1.0, zero on degenerate
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (dg_q[LS-1]) begin
        nrm_d[k] = '0;
      end else if (lane_neg[k]) begin
        nrm_d[k] = -lane_q[k];
      end else if (lane_q[k][F]) begin
        nrm_d[k] = {1'b0, {F{1'b1}}};
      end else begin
        nrm_d[k] = lane_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      for (int k = 0; k < LANES; k++) begin
        nrm_q[k] <= nrm_d[k];
      end
      dg_out_q <= dg_q[LS-1];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = dg_out_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the pipeline has room");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |-> normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
    else $error("non-degenerate triangle gave a zero normal");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted transfer lost at first stage");

endmodule
`default_nettype wire

[test/tb_triangle_unit_normal.sv]
`default_nettype none
module tb_triangle_unit_normal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int NB = 16;
  localparam int LATENCY = NB + 9;
  localparam int CYCLE_LIMIT = 300000;

  typedef logic signed [CB-1:0] coord_t;
  typedef coord_t tri_t [9];
  typedef struct {
    logic signed [NB-1:0] nx;
    logic signed [NB-1:0] ny;
    logic signed [NB-1:0] nz;
    logic                 degen;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t crd [9];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [NB-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  normal_t normals_due[$];
  int errors = 0;
  int cycles = 0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;

  initial begin
    for (int i = 0; i < 9; i++) crd[i] = '0;
  end

  triangle_unit_normal #(.COORD_BITS(CB), .NORMAL_BITS(NB)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_x_i(crd[0]), .first_y_i(crd[1]), .first_z_i(crd[2]),
    .second_x_i(crd[3]), .second_y_i(crd[4]), .second_z_i(crd[5]),
    .third_x_i(crd[6]), .third_y_i(crd[7]), .third_z_i(crd[8]),
    .out_valid_o, .out_ready_i, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // round(|c| * 2^(NB-1) / |C|), ties away from zero, +1.0 saturated
  function automatic logic signed [NB-1:0] quant(longint c, logic [255:0] s);
    logic [255:0] mag, tsh, lhs, dd;
    int q, cand;
    mag = (c < 0) ? 256'(-c) : 256'(c);
    tsh = (mag * mag) << (2 * (NB - 1) + 2);
    q = 0;
    for (int b = NB - 1; b >= 0; b--) begin
      cand = q | (1 << b);
      if (cand <= (1 << (NB - 1))) begin
        dd = 256'(2 * cand - 1);
        lhs = dd * dd * s;
        if (lhs <= tsh) q = cand;
      end
    end
    if (c < 0) return NB'(-q);
    if (q > (1 << (NB - 1)) - 1) q = (1 << (NB - 1)) - 1;
    return NB'(q);
  endfunction

  function automatic normal_t unit_normal(tri_t t);
    longint ax, ay, az, bx, by, bz;
    longint cr [3];
    logic [255:0] s, m;
    normal_t r;
    ax = longint'(t[3]) - longint'(t[0]);
    ay = longint'(t[4]) - longint'(t[1]);
    az = longint'(t[5]) - longint'(t[2]);
    bx = longint'(t[6]) - longint'(t[0]);
    by = longint'(t[7]) - longint'(t[1]);
    bz = longint'(t[8]) - longint'(t[2]);
    cr[0] = ay * bz - az * by;
    cr[1] = az * bx - ax * bz;
    cr[2] = ax * by - ay * bx;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      m = (cr[k] < 0) ? 256'(-cr[k]) : 256'(cr[k]);
      s = s + m * m;
    end
    if (s == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
    end else begin
      r.nx = quant(cr[0], s);
      r.ny = quant(cr[1], s);
      r.nz = quant(cr[2], s);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_triangle(tri_t t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    for (int i = 0; i < 9; i++) crd[i] <= t[i];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    normals_due.push_back(unit_normal(t));
  endtask

  // result checker
  always @(posedge clk_i) begin
    normal_t w;
    if (out_valid_o && out_ready_i) begin
      if (normals_due.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        w = normals_due.pop_front();
        if (normal_x_o !== w.nx) report_mismatch("normal_x", normal_x_o, w.nx);
        if (normal_y_o !== w.ny) report_mismatch("normal_y", normal_y_o, w.ny);
        if (normal_z_o !== w.nz) report_mismatch("normal_z", normal_z_o, w.nz);
        if (degenerate_o !== w.degen) report_mismatch("degenerate", degenerate_o, w.degen);
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        holding = 1'b1;
        repeat (300) @(posedge clk_i);
        holding = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // receiver: random wait per result, ready dropped once a long hold-off starts
  initial begin
    int w;
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0 || holding) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
        while (holding) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && !holding);
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(0, 8191)) - coord_t'(4096);
      default: return coord_t'($urandom_range(0, 15)) - coord_t'(8);
    endcase
  endfunction

  task automatic test_extremes();
    tri_t t;
    coord_t mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    for (int i = 0; i < 9; i++) t[i] = '0;
    send_triangle(t);
    for (int i = 0; i < 9; i++) t[i] = mx;
    send_triangle(t);
    for (int i = 0; i < 9; i++) t[i] = mn;
    send_triangle(t);
    for (int i = 0; i < 9; i++) t[i] = (i < 3) ? mn : (i % 4 == 0) ? mx : mn;
    send_triangle(t);
    for (int i = 0; i < 9; i++) t[i] = (i % 2) ? mx : mn;
    send_triangle(t);
    for (int i = 0; i < 9; i++) t[i] = (i >= 3 && i < 6) ? mx : (i == 7) ? mx : mn;
    send_triangle(t);
    for (int i = 0; i < 9; i++) t[i] = '1;
    send_triangle(t);
  endtask

  // axis-aligned faces give exact +-1.0: positive saturates, negative is kept
  task automatic test_unit_axes();
    tri_t t;
    for (int a = 0; a < 3; a++) begin
      for (int sgn = 0; sgn < 2; sgn++) begin
        for (int i = 0; i < 9; i++) t[i] = '0;
        t[3 + (a + 1) % 3] = 1;
        t[6 + (a + 2) % 3] = sgn ? -1 : 1;
        send_triangle(t);
      end
    end
    for (int i = 0; i < 9; i++) t[i] = '0;
    t[3] = 3; t[7] = 4;
    send_triangle(t);
  endtask

  task automatic test_degenerate();
    tri_t t;
    int k;
    for (int n = 0; n < 6; n++) begin
      k = $urandom_range(0, 4) - 2;
      for (int i = 0; i < 3; i++) begin
        t[i] = rand_coord(1);
        t[3 + i] = t[i] + rand_coord(2);
        t[6 + i] = t[i] + coord_t'(k) * (t[3 + i] - t[i]);
      end
      send_triangle(t);
    end
  endtask

  task automatic test_random(int count);
    tri_t t;
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        // collinear: third = first - (second - first)
        for (int i = 0; i < 3; i++) begin
          t[i] = rand_coord(0);
          t[3 + i] = t[i] + rand_coord(1);
          t[6 + i] = t[i] - (t[3 + i] - t[i]);
        end
      end else begin
        for (int i = 0; i < 9; i++) t[i] = rand_coord(mode < 5 ? 0 : mode < 8 ? 1 : 2);
      end
      send_triangle(t);
    end
  endtask

  task automatic test_backpressure();
    tri_t t;
    hold_req = 1'b1;
    for (int n = 0; n < 60; n++) begin
      for (int i = 0; i < 9; i++) t[i] = rand_coord(0);
      for (int i = 0; i < 9; i++) crd[i] <= t[i];
      in_valid_i <= 1'b1;
      do @(posedge clk_i); while (!in_ready_o);
      normals_due.push_back(unit_normal(t));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_unit_axes();
    test_degenerate();
    test_random(160);
    test_backpressure();
    test_random(160);
    in_valid_i <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
